// ===== hw/rtl/ose_pkg.sv =====
// Shared definitions for the operand stack engine.
// Holds command and status codes, controller states and sizing constants.
// No dependencies.
package ose_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int AMT_W     = 7;
    localparam int MAX_EMIT  = 64;

    typedef enum logic [2:0] {
        CMD_PUSH     = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_POP_MANY = 3'd3,
        CMD_READ_AT  = 3'd4,
        CMD_STORE_AT = 3'd5,
        CMD_SET_SIZE = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_BAD_DEPTH = 3'd3,
        STAT_BAD_SIZE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_FILL
    } state_t;

endpackage

// ===== hw/rtl/ose_stack_ram.sv =====
// Word store of the operand stack engine: one write port, one read port.
// Read data is registered and appears in the cycle after the read request.
// Uses ose_pkg for the word width.
module ose_stack_ram
    import ose_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [WORD_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [WORD_W-1:0] rdata
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/operand_stack_engine.sv =====
// Top level of the operand stack engine: command decode, stack pointer,
// multi-word sequencing and the result register.
// Uses ose_pkg and ose_stack_ram.
//
// Usage: one command word enters on the input channel (in_valid/in_stall) and
// causes one or more result words on the output channel (out_valid/out_stall).
// Push, store, set size by truncation, discarding pop several, unused codes and
// every failing command give their result in the output register in the cycle
// after acceptance; a new command may follow in the next cycle.
// Pop, peek and read at depth go through the synchronous word memory: the
// read data register, then the output register; input is held off in ST_READ.
// An emitting pop several issues one memory read per cycle and delivers one
// word per cycle unless the receiver stalls, deepest first.
// Set size by growth writes one zero word per cycle, then gives its result.
// The memory ports (one read and one write per cycle) set these figures.
// Reset empties the stack at once; word contents are undefined until written.
// While the receiver stalls, the pending result holds and the block accepts
// no further command until the output register frees.
module operand_stack_engine
    import ose_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               cmd,
    input  logic signed [WORD_W-1:0] value,
    input  logic [AMT_W-1:0]         amount,
    input  logic                     emit_popped,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] data,
    output logic [2:0]               status,
    output logic                     last,
    output logic [AMT_W-1:0]         level
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WW     = (CNT_W > AMT_W) ? CNT_W : AMT_W;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         top_reg, top_next;
    logic [CNT_W-1:0]         target_reg, target_next;
    logic [ADDR_W-1:0]        iss_ptr_reg, iss_ptr_next;
    logic [AMT_W-1:0]         iss_left_reg, iss_left_next;
    logic [AMT_W-1:0]         out_left_reg, out_left_next;
    logic                     rd_vld_reg, rd_vld_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    status_t                  status_reg, status_next;
    logic                     last_reg, last_next;
    logic [AMT_W-1:0]         level_reg, level_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic signed [WORD_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic signed [WORD_W-1:0] ram_rdata;

    logic                     out_free;
    logic                     acc;
    logic                     emit_adv;
    logic                     load;
    logic [WW-1:0]            top_w;
    logic [WW-1:0]            amt_w;
    logic [WW-1:0]            top_next_w;
    logic                     full;
    logic                     empty;
    logic                     many_bad;
    logic                     depth_bad;
    logic                     size_bad;
    logic                     emit_go;
    logic                     grow;
    logic [ADDR_W-1:0]        top_addr;
    logic [ADDR_W-1:0]        below_addr;
    logic [ADDR_W-1:0]        depth_addr;

    ose_stack_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = !((state_reg == ST_IDLE) && out_free);
    assign acc        = in_valid && !in_stall;
    assign emit_adv   = !rd_vld_reg || out_free;

    assign top_w      = WW'(top_reg);
    assign amt_w      = WW'(amount);
    assign full       = (top_w == WW'(DEPTH));
    assign empty      = (top_reg == '0);
    assign many_bad   = (amt_w > top_w) || (amt_w > WW'(MAX_EMIT));
    assign depth_bad  = (amt_w >= top_w);
    assign size_bad   = (amt_w > WW'(DEPTH));
    assign emit_go    = emit_popped && (amount != '0);
    assign grow       = (amt_w >= top_w);
    assign top_addr   = ADDR_W'(top_w);
    assign below_addr = ADDR_W'(top_w - WW'(1));
    assign depth_addr = ADDR_W'(top_w - amt_w - WW'(1));
    assign top_next_w = WW'(top_next);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd)
                        CMD_POP, CMD_PEEK:
                        begin
                            if (!empty)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_READ_AT:
                        begin
                            if (!depth_bad)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_POP_MANY:
                        begin
                            if (!many_bad && emit_go)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_SET_SIZE:
                        begin
                            if (!size_bad && grow)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_adv && rd_vld_reg && (out_left_reg == AMT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if ((top_reg == target_reg) && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        top_next      = top_reg;
        target_next   = target_reg;
        iss_ptr_next  = iss_ptr_reg;
        iss_left_next = iss_left_reg;
        out_left_next = out_left_reg;
        rd_vld_next   = rd_vld_reg;
        ram_we        = 1'b0;
        ram_waddr     = top_addr;
        ram_wdata     = value;
        ram_re        = 1'b0;
        ram_raddr     = below_addr;
        load          = 1'b0;
        data_next     = '0;
        status_next   = STAT_OK;
        last_next     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                top_next = top_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (empty)
                            begin
                                load        = 1'b1;
                                status_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re   = 1'b1;
                                top_next = top_reg - CNT_W'(1);
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                load        = 1'b1;
                                status_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                            end
                        end
                        CMD_POP_MANY:
                        begin
                            if (many_bad)
                            begin
                                load        = 1'b1;
                                status_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                top_next = CNT_W'(top_w - amt_w);
                                if (emit_go)
                                begin
                                    iss_ptr_next  = ADDR_W'(top_w - amt_w);
                                    iss_left_next = amount;
                                    out_left_next = amount;
                                    rd_vld_next   = 1'b0;
                                end
                                else
                                begin
                                    load = 1'b1;
                                end
                            end
                        end
                        CMD_READ_AT:
                        begin
                            if (depth_bad)
                            begin
                                load        = 1'b1;
                                status_next = STAT_BAD_DEPTH;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = depth_addr;
                            end
                        end
                        CMD_STORE_AT:
                        begin
                            load = 1'b1;
                            if (depth_bad)
                            begin
                                status_next = STAT_BAD_DEPTH;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = depth_addr;
                            end
                        end
                        CMD_SET_SIZE:
                        begin
                            if (size_bad)
                            begin
                                load        = 1'b1;
                                status_next = STAT_BAD_SIZE;
                            end
                            else if (!grow)
                            begin
                                load     = 1'b1;
                                top_next = CNT_W'(amt_w);
                            end
                            else
                            begin
                                target_next = CNT_W'(amt_w);
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    data_next = ram_rdata;
                end
            end
            ST_EMIT:
            begin
                ram_raddr = iss_ptr_reg;
                if (emit_adv)
                begin
                    if (rd_vld_reg)
                    begin
                        load          = 1'b1;
                        data_next     = ram_rdata;
                        last_next     = (out_left_reg == AMT_W'(1));
                        out_left_next = out_left_reg - AMT_W'(1);
                    end
                    if (iss_left_reg != '0)
                    begin
                        ram_re        = 1'b1;
                        iss_ptr_next  = iss_ptr_reg + ADDR_W'(1);
                        iss_left_next = iss_left_reg - AMT_W'(1);
                        rd_vld_next   = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                    end
                end
            end
            ST_FILL:
            begin
                ram_wdata = '0;
                if (top_reg != target_reg)
                begin
                    ram_we   = 1'b1;
                    top_next = top_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    load = 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        level_next = top_next_w[AMT_W-1:0];

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            iss_left_reg  <= '0;
            out_left_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            iss_left_reg  <= iss_left_next;
            out_left_reg  <= out_left_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        iss_ptr_reg <= iss_ptr_next;
        if (load)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            level_reg  <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign level     = level_reg;

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(top_reg) <= WW'(DEPTH))
        else $error("stack pointer beyond depth");

    a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (out_left_reg != '0) && (iss_left_reg <= out_left_reg))
        else $error("emit counters inconsistent");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (cmd == CMD_PUSH) && !full) |=> (top_reg == $past(top_reg) + CNT_W'(1)))
        else $error("push did not advance the stack pointer");

    a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READ) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("read result not delivered");

endmodule
